// File: hdl/cfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CAN frame cache package
// Result kinds, control states and the response-to-request id table.
// ----------------------------------------------------------------------------
package cfc_pkg;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_FRAME    = 2'd0;
    localparam logic [1:0] OP_ARM      = 2'd1;
    localparam logic [1:0] OP_RD_SLOT  = 2'd2;
    localparam logic [1:0] OP_RD_BYTE  = 2'd3;

    // ISO-TP frame types.
    localparam logic [3:0] TP_SINGLE   = 4'd0;
    localparam logic [3:0] TP_FIRST    = 4'd1;
    localparam logic [3:0] TP_CONSEC   = 4'd2;

    localparam logic [10:0] CACHE_LIMIT = 11'h700;
    localparam logic [11:0] SF_CAP      = 12'd7;
    localparam logic [11:0] FF_CAP      = 12'd1023;

    typedef enum logic [3:0] {
        K_STORED  = 4'd0,
        K_SINGLE  = 4'd1,
        K_FIRST   = 4'd2,
        K_CONSEC  = 4'd3,
        K_DONE    = 4'd4,
        K_ABORT   = 4'd5,
        K_IGNORED = 4'd6,
        K_ARMED   = 4'd7,
        K_REJECT  = 4'd8,
        K_SLOT    = 4'd9,
        K_BYTE    = 4'd10
    } t_kind;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_APPEND = 2'd2,
        S_FINISH = 2'd3
    } t_state;

    // Maps a diagnostic response id to its request id; zero means no pair.
    function automatic logic [10:0] req_lookup(input logic [10:0] rid);
        logic [10:0] req;
        case (rid)
            11'h7ec: req = 11'h7e4;
            11'h7da: req = 11'h7ca;
            11'h7bb: req = 11'h79b;
            11'h77e: req = 11'h75a;
            11'h772: req = 11'h752;
            11'h76d: req = 11'h74d;
            11'h763: req = 11'h743;
            11'h762: req = 11'h742;
            11'h760: req = 11'h740;
            11'h7bc: req = 11'h79c;
            11'h765: req = 11'h745;
            11'h764: req = 11'h744;
            11'h76e: req = 11'h74e;
            11'h793: req = 11'h792;
            11'h7b6: req = 11'h796;
            11'h722: req = 11'h702;
            11'h767: req = 11'h747;
            default: req = 11'h000;
        endcase
        return req;
    endfunction

endpackage
`default_nettype wire

// File: hdl/can_frame_cache_isotp_reassembler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CAN frame cache with ISO-TP receive reassembly
// Keeps the last frame of each low id in a slot memory and reassembles
// ISO-TP messages of one armed response id into a byte-wide message memory.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// input    in         i_valid / o_stall  i_op, i_frame_id, i_dlc, i_byte0..7, i_byte_index
// result   out        o_valid / i_stall  o_kind, o_flow_id, o_msg_length, o_dlc_out, o_data0..7
//
// After reset a clearing pass writes zero to every slot, during which no input
// transaction is taken. A transaction passes from idle to the finish state.
// A frame that feeds the message first passes the append state, which writes
// the data bytes it offers (up to 7) one at a time through the single write
// port of the message memory, then checks for completion.
// A stalled result holds; the next input is taken while it waits.
module can_frame_cache_isotp_reassembler_core #(
    parameter int STORE_SLOTS = 1792,
    parameter int MSG_BYTES   = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_op,
    input  wire  [10:0] i_frame_id,
    input  wire  [3:0]  i_dlc,
    input  wire  [7:0]  i_byte0,
    input  wire  [7:0]  i_byte1,
    input  wire  [7:0]  i_byte2,
    input  wire  [7:0]  i_byte3,
    input  wire  [7:0]  i_byte4,
    input  wire  [7:0]  i_byte5,
    input  wire  [7:0]  i_byte6,
    input  wire  [7:0]  i_byte7,
    input  wire  [9:0]  i_byte_index,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [3:0]  o_kind,
    output logic [10:0] o_flow_id,
    output logic [9:0]  o_msg_length,
    output logic [3:0]  o_dlc_out,
    output logic [7:0]  o_data0,
    output logic [7:0]  o_data1,
    output logic [7:0]  o_data2,
    output logic [7:0]  o_data3,
    output logic [7:0]  o_data4,
    output logic [7:0]  o_data5,
    output logic [7:0]  o_data6,
    output logic [7:0]  o_data7
);

    localparam int SAW = (STORE_SLOTS > 1) ? $clog2(STORE_SLOTS) : 1;
    localparam int MAW = $clog2(MSG_BYTES);

    // Memories: slots hold {dlc, byte7..byte0}.
    logic [67:0] r_store [STORE_SLOTS];
    logic [7:0]  r_msg   [MSG_BYTES];
    logic [67:0] r_store_q;
    logic [7:0]  r_msg_q;

    cfc_pkg::t_state r_state, n_state;
    cfc_pkg::t_kind  r_kind;

    logic [SAW-1:0] r_clr;
    logic           r_armed;
    logic [10:0]    r_resp_id;
    logic [10:0]    r_paired;
    logic [9:0]     r_len;
    logic [9:0]     r_fill;
    logic [3:0]     r_seq;
    logic [10:0]    r_slot;
    logic [9:0]     r_idx;
    logic [7:0]     r_bytes [8];
    logic [3:0]     r_pos;
    logic [3:0]     r_end;
    logic           r_out_valid;

    logic           accept;
    logic           out_free;
    logic           clr_last;
    logic           app_more;
    logic [7:0]     in_bytes [8];
    logic [3:0]     in_type;
    logic [10:0]    in_req;
    logic           in_low_id;
    logic           in_in_store;
    logic           in_session;
    logic           store_we;
    logic [SAW-1:0] store_wa;
    logic [67:0]    store_wd;
    logic           msg_we;

    // Clips a declared length to the frame-type cap and the buffer size.
    function automatic logic [9:0] cap_len(input logic [11:0] v, input logic [11:0] cap);
        logic [12:0] m;
        m = (v > cap) ? {1'b0, cap} : {1'b0, v};
        if (m > 13'(MSG_BYTES)) begin
            m = 13'(MSG_BYTES);
        end
        return 10'(m);
    endfunction

    assign in_bytes[0] = i_byte0;
    assign in_bytes[1] = i_byte1;
    assign in_bytes[2] = i_byte2;
    assign in_bytes[3] = i_byte3;
    assign in_bytes[4] = i_byte4;
    assign in_bytes[5] = i_byte5;
    assign in_bytes[6] = i_byte6;
    assign in_bytes[7] = i_byte7;

    assign o_stall     = (r_state != cfc_pkg::S_IDLE);
    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign clr_last    = (r_clr == SAW'(STORE_SLOTS - 1));
    assign app_more    = (r_pos < r_end);
    assign in_type     = i_byte0[7:4];
    assign in_req      = cfc_pkg::req_lookup(i_frame_id);
    assign in_low_id   = (i_frame_id < cfc_pkg::CACHE_LIMIT);
    assign in_in_store = ({1'b0, i_frame_id} < 12'(STORE_SLOTS));
    assign in_session  = (i_dlc != 4'd0) && r_armed && (i_frame_id == r_resp_id);

    // Slot memory write port: clearing sweep or a cached frame.
    always_comb begin
        store_we = 1'b0;
        store_wa = r_clr;
        store_wd = '0;
        if (r_state == cfc_pkg::S_CLEAR) begin
            store_we = 1'b1;
        end else if (accept && i_op == cfc_pkg::OP_FRAME && in_low_id && in_in_store) begin
            store_we = 1'b1;
            store_wa = SAW'(i_frame_id);
            store_wd = {i_dlc, i_byte7, i_byte6, i_byte5, i_byte4,
                        i_byte3, i_byte2, i_byte1, i_byte0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_wa] <= store_wd;
        end
        if (accept && i_op == cfc_pkg::OP_RD_SLOT) begin
            r_store_q <= r_store[(in_low_id && in_in_store) ? SAW'(i_frame_id) : '0];
        end
    end

    // Message memory: one appended byte per cycle.
    assign msg_we = (r_state == cfc_pkg::S_APPEND) && app_more && (r_fill < r_len);

    always_ff @(posedge i_clk) begin
        if (msg_we) begin
            r_msg[MAW'(r_fill)] <= r_bytes[r_pos[2:0]];
        end
        if (accept && i_op == cfc_pkg::OP_RD_BYTE) begin
            r_msg_q <= r_msg[MAW'(i_byte_index)];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            cfc_pkg::S_CLEAR: begin
                if (clr_last) n_state = cfc_pkg::S_IDLE;
            end
            cfc_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_op == cfc_pkg::OP_FRAME && !in_low_id && in_session &&
                        (in_type == cfc_pkg::TP_SINGLE || in_type == cfc_pkg::TP_FIRST ||
                         (in_type == cfc_pkg::TP_CONSEC && i_byte0[3:0] == r_seq))) begin
                        n_state = cfc_pkg::S_APPEND;
                    end else begin
                        n_state = cfc_pkg::S_FINISH;
                    end
                end
            end
            cfc_pkg::S_APPEND: begin
                if (!app_more) n_state = cfc_pkg::S_FINISH;
            end
            cfc_pkg::S_FINISH: begin
                if (out_free) n_state = cfc_pkg::S_IDLE;
            end
            default: n_state = cfc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Session state and the captured transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_armed   <= 1'b0;
            r_resp_id <= '0;
            r_paired  <= '0;
            r_len     <= '0;
            r_fill    <= '0;
            r_seq     <= 4'd1;
        end else begin
            if (r_state == cfc_pkg::S_CLEAR) begin
                r_clr <= r_clr + SAW'(1);
            end
            if (accept) begin
                r_slot  <= (in_low_id && in_in_store) ? i_frame_id : '0;
                r_idx   <= i_byte_index;
                r_bytes <= in_bytes;
                r_end   <= (i_dlc > 4'd8) ? 4'd8 : i_dlc;
                // A first frame carries its length in byte 0 (low nibble) and byte 1, so data starts at byte 2.
                r_pos   <= (in_type == cfc_pkg::TP_FIRST) ? 4'd2 : 4'd1;
                case (i_op)
                    cfc_pkg::OP_FRAME: begin
                        if (in_low_id) begin
                            r_kind <= cfc_pkg::K_STORED;
                        end else if (!in_session) begin
                            r_kind <= cfc_pkg::K_IGNORED;
                        end else if (in_type == cfc_pkg::TP_SINGLE) begin
                            r_kind  <= cfc_pkg::K_SINGLE;
                            r_len   <= cap_len({8'd0, i_byte0[3:0]}, cfc_pkg::SF_CAP);
                            r_fill  <= '0;
                            r_armed <= 1'b0;
                        end else if (in_type == cfc_pkg::TP_FIRST) begin
                            r_kind <= cfc_pkg::K_FIRST;
                            r_len  <= cap_len({i_byte0[3:0], i_byte1}, cfc_pkg::FF_CAP);
                            r_fill <= '0;
                            r_seq  <= 4'd1;
                        end else if (in_type == cfc_pkg::TP_CONSEC) begin
                            if (i_byte0[3:0] == r_seq) begin
                                r_kind <= cfc_pkg::K_CONSEC;
                                r_seq  <= r_seq + 4'd1;
                            end else begin
                                r_kind  <= cfc_pkg::K_ABORT;
                                r_armed <= 1'b0;
                            end
                        end else begin
                            r_kind <= cfc_pkg::K_IGNORED;
                        end
                    end
                    cfc_pkg::OP_ARM: begin
                        if (in_low_id) begin
                            r_kind <= cfc_pkg::K_REJECT;
                        end else if (in_req == 11'd0) begin
                            r_kind  <= cfc_pkg::K_REJECT;
                            r_armed <= 1'b0;
                        end else begin
                            r_kind    <= cfc_pkg::K_ARMED;
                            r_armed   <= 1'b1;
                            r_resp_id <= i_frame_id;
                            r_paired  <= in_req;
                        end
                    end
                    cfc_pkg::OP_RD_SLOT: r_kind <= cfc_pkg::K_SLOT;
                    default:             r_kind <= cfc_pkg::K_BYTE;
                endcase
            end
            // Append phase: a byte goes in while the message has room.
            if (r_state == cfc_pkg::S_APPEND) begin
                if (app_more) begin
                    r_pos <= r_pos + 4'd1;
                    if (msg_we) begin
                        r_fill <= r_fill + 10'd1;
                    end
                end else if (r_kind == cfc_pkg::K_CONSEC && r_fill == r_len) begin
                    r_kind  <= cfc_pkg::K_DONE;
                    r_armed <= 1'b0;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == cfc_pkg::S_FINISH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cfc_pkg::S_FINISH && out_free) begin
            o_kind       <= r_kind;
            o_flow_id    <= '0;
            o_msg_length <= '0;
            o_dlc_out    <= '0;
            {o_data7, o_data6, o_data5, o_data4,
             o_data3, o_data2, o_data1, o_data0} <= '0;
            case (r_kind)
                cfc_pkg::K_SINGLE, cfc_pkg::K_FIRST, cfc_pkg::K_CONSEC,
                cfc_pkg::K_DONE, cfc_pkg::K_ABORT: begin
                    o_flow_id    <= r_paired;
                    o_msg_length <= r_len;
                end
                cfc_pkg::K_ARMED: o_flow_id <= r_paired;
                cfc_pkg::K_SLOT: begin
                    o_flow_id <= r_slot;
                    o_dlc_out <= r_store_q[67:64];
                    {o_data7, o_data6, o_data5, o_data4,
                     o_data3, o_data2, o_data1, o_data0} <= r_store_q[63:0];
                end
                cfc_pkg::K_BYTE: begin
                    o_msg_length <= r_len;
                    // Beyond the buffer, or declared but not yet received, reads zero.
                    if ({3'd0, r_idx} < 13'(MSG_BYTES) &&
                        !(r_idx < r_len && r_idx >= r_fill)) begin
                        o_data0 <= r_msg_q;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// File: sim/can_frame_cache_isotp_reassembler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN frame cache reassembly checker
// Watches both channels, predicts each result from the accepted input
// transactions and compares it with the result the block delivers.
// ----------------------------------------------------------------------------
module can_frame_cache_isotp_reassembler_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire         o_stall,
    input  wire  [1:0]  i_op,
    input  wire  [10:0] i_frame_id,
    input  wire  [3:0]  i_dlc,
    input  wire  [63:0] i_bytes,
    input  wire  [9:0]  i_byte_index,
    input  wire         o_valid,
    input  wire         i_stall,
    input  wire  [3:0]  o_kind,
    input  wire  [10:0] o_flow_id,
    input  wire  [9:0]  o_msg_length,
    input  wire  [3:0]  o_dlc_out,
    input  wire  [63:0] o_data,
    output int          o_errors,
    output int          o_pending,
    output logic [9:0]  o_fill_level
);

    localparam int SLOTS = 1792;
    localparam int MSG_MAX = 1024;

    typedef struct packed {
        logic [3:0]      kind;
        logic [10:0]     flow;
        logic [9:0]      len;
        logic [3:0]      dlc;
        logic [7:0][7:0] data;
    } t_result;

    // Response id and its request id, one pair per entry.
    localparam logic [10:0] RESP_IDS [17] = '{11'h7ec, 11'h7da, 11'h7bb, 11'h77e,
        11'h772, 11'h76d, 11'h763, 11'h762, 11'h760, 11'h7bc, 11'h765, 11'h764,
        11'h76e, 11'h793, 11'h7b6, 11'h722, 11'h767};
    localparam logic [10:0] REQ_IDS [17] = '{11'h7e4, 11'h7ca, 11'h79b, 11'h75a,
        11'h752, 11'h74d, 11'h743, 11'h742, 11'h740, 11'h79c, 11'h745, 11'h744,
        11'h74e, 11'h792, 11'h796, 11'h702, 11'h747};

    logic [7:0][7:0] slot_bytes [SLOTS];
    logic [3:0]      slot_dlc [SLOTS];
    logic [7:0]      msg_mem [MSG_MAX];
    logic            armed;
    logic [10:0]     resp_id;
    logic [10:0]     req_id;
    logic [9:0]      msg_len;
    logic [9:0]      fill;
    logic [3:0]      next_seq;
    t_result         expected_results [$];

    assign o_pending    = expected_results.size();
    assign o_fill_level = fill;

    function automatic logic [10:0] pair_of(input logic [10:0] rid);
        logic [10:0] req;
        req = '0;
        for (int i = 0; i < 17; i++) begin
            if (RESP_IDS[i] == rid) req = REQ_IDS[i];
        end
        return req;
    endfunction

    function automatic logic [9:0] capped(input int len, input int cap);
        int l;
        l = len;
        if (l > cap) l = cap;
        if (l > MSG_MAX) l = MSG_MAX;
        return l[9:0];
    endfunction

    // A new message reads as zero over its declared length until filled.
    task automatic start_message(input logic [9:0] len);
        msg_len = len;
        for (int i = 0; i < int'(len); i++) begin
            msg_mem[i] = '0;
        end
        fill = '0;
    endtask

    // Appends data bytes from position 'from' up to the DLC, at most eight.
    task automatic append_bytes(input logic [7:0][7:0] b, input int from, input int dlc);
        int n;
        n = (dlc > 8) ? 8 : dlc;
        for (int i = from; i < n; i++) begin
            if (fill < msg_len) begin
                msg_mem[fill] = b[i];
                fill = fill + 10'd1;
            end
        end
    endtask

    // Works out the result of one transaction and advances the session state.
    task automatic reassemble(input logic [1:0] op, input logic [10:0] id,
                              input logic [3:0] dlc, input logic [7:0][7:0] b,
                              input logic [9:0] idx, output t_result r);
        logic [10:0] req;
        int slot;
        r = '0;
        case (op)
            cfc_pkg::OP_FRAME: begin
                if (id < cfc_pkg::CACHE_LIMIT) begin
                    if (id < SLOTS) begin
                        slot_bytes[id] = b;
                        slot_dlc[id] = dlc;
                    end
                    r.kind = cfc_pkg::K_STORED;
                end else if (dlc != 0 && armed && id == resp_id) begin
                    case (b[0][7:4])
                        cfc_pkg::TP_SINGLE: begin
                            start_message(capped(b[0][3:0], 7));
                            append_bytes(b, 1, dlc);
                            armed = 1'b0;
                            r.kind = cfc_pkg::K_SINGLE;
                        end
                        cfc_pkg::TP_FIRST: begin
                            start_message(capped({b[0][3:0], b[1]}, 1023));
                            next_seq = 4'd1;
                            append_bytes(b, 2, dlc);
                            r.kind = cfc_pkg::K_FIRST;
                        end
                        cfc_pkg::TP_CONSEC: begin
                            if (b[0][3:0] == next_seq) begin
                                append_bytes(b, 1, dlc);
                                next_seq = next_seq + 4'd1;
                                if (fill == msg_len) begin
                                    armed = 1'b0;
                                    r.kind = cfc_pkg::K_DONE;
                                end else begin
                                    r.kind = cfc_pkg::K_CONSEC;
                                end
                            end else begin
                                armed = 1'b0;
                                r.kind = cfc_pkg::K_ABORT;
                            end
                        end
                        default: r.kind = cfc_pkg::K_IGNORED;
                    endcase
                    if (r.kind != cfc_pkg::K_IGNORED) begin
                        r.flow = req_id;
                        r.len = msg_len;
                    end
                end else begin
                    r.kind = cfc_pkg::K_IGNORED;
                end
            end
            cfc_pkg::OP_ARM: begin
                req = pair_of(id);
                if (id < cfc_pkg::CACHE_LIMIT) begin
                    r.kind = cfc_pkg::K_REJECT;
                end else if (req == '0) begin
                    armed = 1'b0;
                    r.kind = cfc_pkg::K_REJECT;
                end else begin
                    armed = 1'b1;
                    resp_id = id;
                    req_id = req;
                    r.kind = cfc_pkg::K_ARMED;
                    r.flow = req;
                end
            end
            cfc_pkg::OP_RD_SLOT: begin
                slot = (id < cfc_pkg::CACHE_LIMIT && id < SLOTS) ? int'(id) : 0;
                r.kind = cfc_pkg::K_SLOT;
                r.flow = slot[10:0];
                r.dlc = slot_dlc[slot];
                r.data = slot_bytes[slot];
            end
            default: begin
                r.kind = cfc_pkg::K_BYTE;
                r.len = msg_len;
                r.data[0] = msg_mem[idx];
            end
        endcase
    endtask

    // Compare delivered results, then predict from the accepted input.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_bytes[i] = '0;
                slot_dlc[i] = '0;
            end
            armed = 1'b0;
            resp_id = '0;
            req_id = '0;
            msg_len = '0;
            fill = '0;
            next_seq = 4'd1;
            o_errors = 0;
            expected_results.delete();
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_kind, o_flow_id, o_msg_length, o_dlc_out, o_data};
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %p", $time, got);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected %p, actual %p", $time, want, got);
                        o_errors++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                reassemble(i_op, i_frame_id, i_dlc, i_bytes, i_byte_index, want);
                expected_results.push_back(want);
            end
        end
    end

endmodule

// File: sim/can_frame_cache_isotp_reassembler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN frame cache testbench
// Drives directed and random frame, arm and read transactions with random
// idling on both channels; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module can_frame_cache_isotp_reassembler_core_tb;

    localparam int WATCHDOG_LIMIT = 50000;
    localparam logic [10:0] RESP_IDS [17] = '{11'h7ec, 11'h7da, 11'h7bb, 11'h77e,
        11'h772, 11'h76d, 11'h763, 11'h762, 11'h760, 11'h7bc, 11'h765, 11'h764,
        11'h76e, 11'h793, 11'h7b6, 11'h722, 11'h767};

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            i_stall = 1'b1;
    logic [1:0]      i_op = '0;
    logic [10:0]     i_frame_id = '0;
    logic [3:0]      i_dlc = '0;
    logic [7:0][7:0] i_bytes = '0;
    logic [9:0]      i_byte_index = '0;
    wire             o_stall;
    wire             o_valid;
    wire  [3:0]      o_kind;
    wire  [10:0]     o_flow_id;
    wire  [9:0]      o_msg_length;
    wire  [3:0]      o_dlc_out;
    wire  [7:0]      o_data0, o_data1, o_data2, o_data3;
    wire  [7:0]      o_data4, o_data5, o_data6, o_data7;
    int              errors;
    int              pending;
    logic [9:0]      fill_level;
    logic            quiet = 1'b0;
    logic            hold_req = 1'b0;
    logic            held = 1'b0;
    int              sent = 0;
    int              idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    can_frame_cache_isotp_reassembler_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_frame_id(i_frame_id), .i_dlc(i_dlc),
        .i_byte0(i_bytes[0]), .i_byte1(i_bytes[1]), .i_byte2(i_bytes[2]),
        .i_byte3(i_bytes[3]), .i_byte4(i_bytes[4]), .i_byte5(i_bytes[5]),
        .i_byte6(i_bytes[6]), .i_byte7(i_bytes[7]), .i_byte_index(i_byte_index),
        .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind), .o_flow_id(o_flow_id),
        .o_msg_length(o_msg_length), .o_dlc_out(o_dlc_out),
        .o_data0(o_data0), .o_data1(o_data1), .o_data2(o_data2), .o_data3(o_data3),
        .o_data4(o_data4), .o_data5(o_data5), .o_data6(o_data6), .o_data7(o_data7)
    );

    can_frame_cache_isotp_reassembler_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_frame_id(i_frame_id), .i_dlc(i_dlc), .i_bytes(i_bytes),
        .i_byte_index(i_byte_index), .o_valid(o_valid), .i_stall(i_stall),
        .o_kind(o_kind), .o_flow_id(o_flow_id), .o_msg_length(o_msg_length),
        .o_dlc_out(o_dlc_out),
        .o_data({o_data7, o_data6, o_data5, o_data4, o_data3, o_data2, o_data1, o_data0}),
        .o_errors(errors), .o_pending(pending), .o_fill_level(fill_level)
    );

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        logic v;
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = quiet ? 0 : $urandom_range(0, 8);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                v = o_valid;
                @(posedge i_clk);
            end while (!v);
        end
    end

    // Offers one transaction and waits until it is accepted. A byte read
    // picks its index from the part of the message already filled.
    task automatic send(input logic [1:0] op, input logic [10:0] id, input logic [3:0] dlc,
                        input logic [7:0][7:0] b, input logic [9:0] idx);
        int gap;
        logic s;
        logic [9:0] pos;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (op == cfc_pkg::OP_RD_BYTE && gap == 0) gap = 1;
        pos = idx;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap - 1) @(posedge i_clk);
            @(negedge i_clk);
            if (op == cfc_pkg::OP_RD_BYTE) begin
                pos = (fill_level == 0) ? 10'd0 : 10'(idx % fill_level);
            end
            @(posedge i_clk);
        end
        // Nothing received yet: read a slot instead of an unwritten byte.
        if (op == cfc_pkg::OP_RD_BYTE && fill_level == 0) op = cfc_pkg::OP_RD_SLOT;
        i_op <= op;
        i_frame_id <= id;
        i_dlc <= dlc;
        i_bytes <= b;
        i_byte_index <= pos;
        i_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            s = o_stall;
            @(posedge i_clk);
        end while (s);
        sent++;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic frame(input logic [10:0] id, input logic [3:0] dlc, input logic [7:0][7:0] b);
        send(cfc_pkg::OP_FRAME, id, dlc, b, 10'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Unrelated traffic that may fall between the frames of a message.
    task automatic noise();
        logic [7:0][7:0] b;
        b = rnd64();
        case ($urandom_range(0, 5))
            0, 1: frame(11'($urandom_range(0, 'h6ff)), 4'($urandom), b);
            2: send(cfc_pkg::OP_RD_SLOT, 11'($urandom), 4'($urandom), b, 10'($urandom));
            3: send(cfc_pkg::OP_RD_BYTE, 11'($urandom), 4'($urandom), b, 10'($urandom));
            4: frame(11'($urandom_range('h700, 'h7ff)), 4'($urandom), b);
            default: send(2'($urandom), 11'($urandom), 4'($urandom), b, 10'($urandom));
        endcase
    endtask

    // One ISO-TP session: arm, then a single frame or a first frame and
    // its consecutive frames, with occasional faults and foreign traffic.
    task automatic session(input bit long_msg);
        logic [7:0][7:0] b;
        logic [10:0] rid;
        logic [3:0] seq;
        logic [3:0] dlc;
        int len;
        int frames;
        rid = RESP_IDS[$urandom_range(0, 16)];
        if ($urandom_range(0, 19) == 0) rid = 11'($urandom);
        send(cfc_pkg::OP_ARM, rid, 4'($urandom), rnd64(), 10'($urandom));
        b = rnd64();
        dlc = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        if ($urandom_range(0, 4) == 0) begin
            b[0][7:4] = cfc_pkg::TP_SINGLE;
            frame(rid, dlc, b);
        end else begin
            len = long_msg ? $urandom_range(600, 4095)
                           : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 130)
                                                         : $urandom_range(1, 30));
            b[0] = {cfc_pkg::TP_FIRST, 4'(len >> 8)};
            b[1] = 8'(len);
            frame(rid, ($urandom_range(0, 9) == 0) ? dlc : 4'd8, b);
            frames = ((len > 1023 ? 1023 : len) + 6) / 7 + 1;
            seq = 4'd1;
            for (int i = 0; i < frames; i++) begin
                if ($urandom_range(0, 5) == 0) noise();
                b = rnd64();
                b[0] = {cfc_pkg::TP_CONSEC, seq};
                if ($urandom_range(0, 39) == 0) b[0][3:0] = 4'($urandom);
                if ($urandom_range(0, 49) == 0) b[0][7:4] = 4'($urandom_range(3, 15));
                frame(rid, ($urandom_range(0, 9) == 0) ? dlc : 4'd8, b);
                seq = seq + 4'd1;
            end
        end
        repeat ($urandom_range(0, 4)) begin
            send(cfc_pkg::OP_RD_BYTE, '0, '0, rnd64(), 10'($urandom));
        end
    endtask

    initial begin
        logic [7:0][7:0] ones;
        ones = '1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: slot extremes, arm rejects, single, first, abort and
        // short messages, foreign and unknown frame types.
        send(cfc_pkg::OP_RD_SLOT, 11'h000, '0, '0, '0);
        frame(11'h6ff, 4'hf, ones);
        frame(11'h000, 4'h0, 64'h0123456789abcdef);
        send(cfc_pkg::OP_RD_SLOT, 11'h6ff, '0, '0, '1);
        send(cfc_pkg::OP_RD_SLOT, 11'h7ff, '0, '0, '0);
        send(cfc_pkg::OP_ARM, 11'h100, '0, '0, '0);
        send(cfc_pkg::OP_ARM, 11'h7ff, '0, '0, '0);
        send(cfc_pkg::OP_ARM, 11'h7ec, '0, '0, '0);
        frame(11'h7ec, 4'd8, 64'h1122334455667708);
        send(cfc_pkg::OP_RD_BYTE, '0, '0, '0, 10'd6);
        send(cfc_pkg::OP_ARM, 11'h722, '0, '0, '0);
        frame(11'h722, 4'd8, 64'h665544332211ff1f);
        frame(11'h722, 4'hf, 64'h77665544332211_21);
        frame(11'h722, 4'd8, 64'h0000000000000023);
        send(cfc_pkg::OP_ARM, 11'h767, '0, '0, '0);
        frame(11'h767, 4'd8, 64'h00000000000000f0);
        frame(11'h767, 4'd0, 64'h0000000000000000);
        frame(11'h7e4, 4'd8, 64'h0000000000000000);
        frame(11'h767, 4'd8, 64'hddccbbaa99880210);
        frame(11'h767, 4'd8, 64'h5555555555555521);
        send(cfc_pkg::OP_ARM, 11'h767, '0, '0, '0);
        frame(11'h767, 4'd2, 64'h0000000000004422);
        send(cfc_pkg::OP_RD_BYTE, '0, '0, '0, 10'd1);
        drain();

        // Random sessions, with one long hold-off of the result side, during which
        // input comes without idling, and a second quiet stretch without idling.
        while (sent < 950) begin
            if (sent > 300 && !held) begin
                held = 1'b1;
                hold_req = 1'b1;
                quiet = 1'b1;
                repeat (40) noise();
                quiet = 1'b0;
                drain();
            end
            quiet = (sent > 600 && sent < 700);
            session($urandom_range(0, 39) == 0);
            if ($urandom_range(0, 2) == 0) noise();
        end
        drain();

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
